// ===== sv/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

  localparam int MaxBeats = 6;
  localparam int BeatIdxW = 3;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;

  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChCsi   = 8'h9b;
  localparam logic [7:0] ChOsc   = 8'h9d;
  localparam logic [7:0] ChSt    = 8'h9c;
  localparam logic [7:0] ChDcs   = 8'h90;
  localparam logic [7:0] ChSos   = 8'h98;
  localparam logic [7:0] ChPm    = 8'h9e;
  localparam logic [7:0] ChApc   = 8'h9f;
  localparam logic [7:0] ChFinLo = 8'h40;
  localparam logic [7:0] ChFinHi = 8'h7e;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChRbr   = 8'h5d;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChCaret = 8'h5e;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] Utf2Lo  = 8'hc2;
  localparam logic [7:0] Utf3Lo  = 8'he0;
  localparam logic [7:0] Utf4Lo  = 8'hf0;
  localparam logic [7:0] UtfBad  = 8'hf8;

  typedef struct packed {
    logic [MaxBeats-1:0][7:0] bytes;
    logic [BeatIdxW-1:0]      count;
  } burst_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } seq_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end
    return 8'h57 + {4'h0, v};
  endfunction

  function automatic seq_t ctrl_seq(input logic [7:0] c);
    seq_t s;
    s = '0;
    s.b[0] = ChBsl;
    if (c == ChBs) begin
      s.b[1] = ChLowB;
      s.n = 3'd2;
    end else if (c == ChBel) begin
      s.b[1] = ChLowA;
      s.n = 3'd2;
    end else begin
      s.b[1] = ChLowX;
      s.b[2] = hex_digit(c[7:4]);
      s.b[3] = hex_digit(c[3:0]);
      s.n = 3'd4;
    end
    return s;
  endfunction

  function automatic burst_t app1(input burst_t acc, input logic [7:0] x);
    burst_t r;
    r = acc;
    if (acc.count < BeatIdxW'(MaxBeats)) begin
      r.bytes[acc.count] = x;
      r.count = acc.count + BeatIdxW'(1);
    end
    return r;
  endfunction

  function automatic burst_t app_seq(input burst_t acc, input seq_t s);
    burst_t r;
    r = acc;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < s.n) begin
        r = app1(r, s.b[k]);
      end
    end
    return r;
  endfunction

  function automatic burst_t app_cr(input burst_t acc, input logic sl);
    burst_t r;
    r = acc;
    if (sl) begin
      r = app1(r, ChSp);
    end else begin
      r = app1(r, ChBsl);
      r = app1(r, ChLowR);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tts_front.sv =====
`default_nettype none
module tts_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            byte_valid,
  input  wire logic            finish,
  output tts_pkg::burst_t      burst,
  output logic                 burst_push
);

  localparam logic [2:0] ST_TEXT    = 3'd0;
  localparam logic [2:0] ST_ESC     = 3'd1;
  localparam logic [2:0] ST_CSI     = 3'd2;
  localparam logic [2:0] ST_OSC     = 3'd3;
  localparam logic [2:0] ST_OSC_ESC = 3'd4;
  localparam logic [2:0] ST_STR     = 3'd5;
  localparam logic [2:0] ST_STR_ESC = 3'd6;
  localparam logic [2:0] ST_BAD     = 3'd7;

  logic            single_line;
  logic [2:0]      pstate;
  logic [2:0]      pstate_next;
  logic            hcr;
  logic            hcr_next;
  logic [1:0]      gcnt;
  logic [1:0]      gcnt_next;
  logic [7:0]      gbytes [3];
  logic [7:0]      gbytes_next [3];

  tts_pkg::burst_t acc;
  logic            taken;
  logic            cont;
  logic [7:0]      lead;
  logic [2:0]      need;

  always_comb begin
    acc = '0;
    pstate_next = pstate;
    hcr_next = hcr;
    gcnt_next = gcnt;
    gbytes_next = gbytes;
    taken = 1'b0;
    cont = 1'b0;
    lead = gbytes[0];
    if (lead >= tts_pkg::Utf4Lo) begin
      need = 3'd4;
    end else if (lead >= tts_pkg::Utf3Lo) begin
      need = 3'd3;
    end else begin
      need = 3'd2;
    end

    if (byte_valid) begin
      if (gcnt != 2'd0) begin
        cont = (in_byte[7:6] == 2'b10);
        if (gcnt == 2'd1 && lead == tts_pkg::Utf3Lo && !in_byte[5]) begin
          cont = 1'b0;
        end
        if (gcnt == 2'd1 && lead == tts_pkg::Utf4Lo && in_byte[5:4] == 2'b00) begin
          cont = 1'b0;
        end
        if (cont) begin
          taken = 1'b1;
          if ({1'b0, gcnt} + 3'd1 >= need) begin
            gcnt_next = 2'd0;
            if (need == 3'd2 && lead == tts_pkg::Utf2Lo && in_byte <= tts_pkg::ChApc) begin
              acc = tts_pkg::app_seq(acc, tts_pkg::ctrl_seq(in_byte));
            end else begin
              for (int k = 0; k < 3; k++) begin
                if (2'(k) < gcnt) begin
                  acc = tts_pkg::app1(acc, gbytes[k]);
                end
              end
              acc = tts_pkg::app1(acc, in_byte);
            end
          end else begin
            gbytes_next[gcnt] = in_byte;
            gcnt_next = gcnt + 2'd1;
          end
        end
      end

      if (!taken) begin
        gcnt_next = 2'd0;
        if (pstate == ST_BAD) begin
          pstate_next = ST_TEXT;
          hcr_next = 1'b0;
        end
        case (pstate_next)
          ST_TEXT: begin
            if (in_byte inside {tts_pkg::ChEsc, tts_pkg::ChCsi, tts_pkg::ChOsc,
                                tts_pkg::ChDcs, tts_pkg::ChSos, tts_pkg::ChPm,
                                tts_pkg::ChApc}) begin
              if (hcr_next) begin
                hcr_next = 1'b0;
                acc = tts_pkg::app_cr(acc, single_line);
              end
              if (in_byte == tts_pkg::ChEsc) begin
                pstate_next = ST_ESC;
              end else if (in_byte == tts_pkg::ChCsi) begin
                pstate_next = ST_CSI;
              end else if (in_byte == tts_pkg::ChOsc) begin
                pstate_next = ST_OSC;
              end else begin
                pstate_next = ST_STR;
              end
            end else if (hcr_next && in_byte == tts_pkg::ChLf) begin
              hcr_next = 1'b0;
              acc = tts_pkg::app1(acc, single_line ? tts_pkg::ChSp : tts_pkg::ChLf);
            end else begin
              if (hcr_next) begin
                hcr_next = 1'b0;
                acc = tts_pkg::app_cr(acc, single_line);
              end
              if (in_byte == tts_pkg::ChCr) begin
                hcr_next = 1'b1;
              end else if (!in_byte[7]) begin
                if (in_byte == tts_pkg::ChLf || in_byte == tts_pkg::ChTab) begin
                  acc = tts_pkg::app1(acc, single_line ? tts_pkg::ChSp : in_byte);
                end else if (in_byte < tts_pkg::ChSp || in_byte == tts_pkg::ChDel) begin
                  acc = tts_pkg::app_seq(acc, tts_pkg::ctrl_seq(in_byte));
                end else begin
                  acc = tts_pkg::app1(acc, in_byte);
                end
              end else if (in_byte >= tts_pkg::Utf2Lo && in_byte < tts_pkg::UtfBad) begin
                gbytes_next[0] = in_byte;
                gcnt_next = 2'd1;
              end
            end
          end
          ST_ESC: begin
            if (in_byte == tts_pkg::ChLbr) begin
              pstate_next = ST_CSI;
            end else if (in_byte == tts_pkg::ChRbr) begin
              pstate_next = ST_OSC;
            end else if (in_byte inside {tts_pkg::ChP, tts_pkg::ChX, tts_pkg::ChCaret,
                                         tts_pkg::ChUnder}) begin
              pstate_next = ST_STR;
            end else if (in_byte == tts_pkg::ChEsc) begin
              pstate_next = ST_ESC;
            end else begin
              pstate_next = ST_TEXT;
            end
          end
          ST_CSI: begin
            if (in_byte inside {[tts_pkg::ChFinLo:tts_pkg::ChFinHi]}) begin
              pstate_next = ST_TEXT;
            end else if (in_byte == tts_pkg::ChEsc) begin
              pstate_next = ST_ESC;
            end
          end
          ST_OSC: begin
            if (in_byte == tts_pkg::ChBel || in_byte == tts_pkg::ChSt) begin
              pstate_next = ST_TEXT;
            end else if (in_byte == tts_pkg::ChEsc) begin
              pstate_next = ST_OSC_ESC;
            end
          end
          ST_OSC_ESC: begin
            if (in_byte == tts_pkg::ChBsl) begin
              pstate_next = ST_TEXT;
            end else if (in_byte != tts_pkg::ChEsc) begin
              pstate_next = ST_OSC;
            end
          end
          ST_STR: begin
            if (in_byte == tts_pkg::ChSt) begin
              pstate_next = ST_TEXT;
            end else if (in_byte == tts_pkg::ChEsc) begin
              pstate_next = ST_STR_ESC;
            end
          end
          ST_STR_ESC: begin
            if (in_byte == tts_pkg::ChBsl) begin
              pstate_next = ST_TEXT;
            end else if (in_byte != tts_pkg::ChEsc) begin
              pstate_next = ST_STR;
            end
          end
          default: begin
            pstate_next = ST_TEXT;
          end
        endcase
      end
    end

    if (finish) begin
      if (hcr_next) begin
        acc = tts_pkg::app_cr(acc, single_line);
      end
      pstate_next = ST_TEXT;
      hcr_next = 1'b0;
      gcnt_next = 2'd0;
    end
  end

  assign burst = acc;
  assign burst_push = accept && (acc.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      single_line <= 1'b0;
      pstate <= ST_TEXT;
      hcr <= 1'b0;
      gcnt <= 2'd0;
    end else begin
      if (cfg_write) begin
        single_line <= cfg_data;
      end
      if (accept) begin
        pstate <= pstate_next;
        hcr <= hcr_next;
        gcnt <= gcnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gbytes <= gbytes_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tts_queue.sv =====
`default_nettype none
module tts_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire tts_pkg::burst_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output tts_pkg::burst_t      head,
  output logic                 head_valid
);

  tts_pkg::burst_t              entries [tts_pkg::QDepth];
  logic [tts_pkg::QPtrW-1:0]    wr_ptr;
  logic [tts_pkg::QPtrW-1:0]    rd_ptr;
  logic [tts_pkg::QCntW-1:0]    count;
  logic                         do_wr;
  logic                         do_rd;

  assign full = (count == tts_pkg::QCntW'(tts_pkg::QDepth));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + tts_pkg::QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + tts_pkg::QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + tts_pkg::QCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - tts_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tts_back.sv =====
`default_nettype none
module tts_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tts_pkg::burst_t head,
  input  wire logic            head_valid,
  output logic                 head_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [tts_pkg::BeatIdxW-1:0] idx;
  logic                         beat;

  assign empty = !head_valid;
  assign out_byte = head.bytes[idx];
  assign out_last = (idx == head.count - tts_pkg::BeatIdxW'(1));
  assign beat = pop && head_valid;
  assign head_pop = beat && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat) begin
      if (out_last) begin
        idx <= '0;
      end else begin
        idx <= idx + tts_pkg::BeatIdxW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/terminal_text_sanitizer_unit.sv =====
// Terminal text sanitizer: strips escape sequences, checks UTF-8, folds CRLF
// and turns control codes into visible backslash text.
// Input side is a queue: drive in_byte, byte_valid and finish with push; a beat
// is taken when push is high and full is low. Output side is a queue too: the
// oldest byte sits on out_byte while empty is low and leaves when pop is high;
// out_last marks the final byte that one input beat produced.
// A beat that produces bytes shows its first byte the cycle after it is taken,
// unless a group is ahead. The front parser takes one beat per cycle while full
// is low; each beat yields 0 to 6 bytes, and the back end sends one byte per
// cycle while pop is high, from a 4-entry queue of byte groups, so full rises
// only when that queue fills because of expansion or a stalled receiver. While
// pop stays low the head byte holds and input beats flow until the queue fills.
// cfg_write/cfg_data set single-line mode (LF, TAB, CR become spaces); write
// it only while the block is idle.
// Synchronous reset empties the queue, returns the parser to text state,
// drops any held CR or partial UTF-8 sequence and clears single-line mode.
`default_nettype none
module terminal_text_sanitizer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       byte_valid,
  input  wire logic       finish,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic            accept;
  tts_pkg::burst_t burst;
  logic            burst_push;
  tts_pkg::burst_t q_head;
  logic            q_head_valid;
  logic            q_pop;

  assign accept = push && !full;

  tts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .in_byte    (in_byte),
    .byte_valid (byte_valid),
    .finish     (finish),
    .burst      (burst),
    .burst_push (burst_push)
  );

  tts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (burst_push),
    .wr_data    (burst),
    .full       (full),
    .rd_en      (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  tts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .head_pop   (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

`ifndef ASSERT_OFF
  a_group_size: assert property (@(posedge clk) disable iff (rst)
    q_head_valid |-> (q_head.count != '0 &&
                      q_head.count <= tts_pkg::BeatIdxW'(tts_pkg::MaxBeats)))
    else $error("queued byte group has a bad size");

  a_group_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !out_last) |=> !empty)
    else $error("byte group left before its last beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("output not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tts_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles = 150;

  typedef enum logic [2:0] {
    PS_TEXT, PS_ESC, PS_CSI, PS_OSC, PS_OSC_ESC, PS_STR, PS_STR_ESC
  } scan_state_e;

  typedef struct packed {
    logic [7:0] b;
    logic       v;
    logic       fin;
  } tty_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       byte_valid = 1'b0;
  logic       finish = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  terminal_text_sanitizer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .byte_valid (byte_valid),
    .finish     (finish),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sanitizer state as the testbench tracks it
  bit          mode_sl = 1'b0;
  scan_state_e scan_st = PS_TEXT;
  bit          cr_held = 1'b0;
  logic [7:0]  u8_buf [3];
  int          u8_cnt = 0;
  logic [7:0]  burst_q [$];

  tty_item_t   pend_q [$];
  text_beat_t  want_text_q [$];
  int          items_queued = 0;
  int          err_cnt = 0;
  int          stall_cyc = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  function automatic void put_b(input logic [7:0] b);
    if (burst_q.size() < MaxBeats) begin
      burst_q.push_back(b);
    end
  endfunction

  function automatic logic [7:0] hex_ch(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + 8'(v);
    end
    return 8'h61 + 8'(v - 4'd10);
  endfunction

  function automatic void put_ctrl(input logic [7:0] c);
    put_b(ChBsl);
    if (c == ChBs) begin
      put_b(ChLowB);
    end else if (c == ChBel) begin
      put_b(ChLowA);
    end else begin
      put_b(ChLowX);
      put_b(hex_ch(c[7:4]));
      put_b(hex_ch(c[3:0]));
    end
  endfunction

  function automatic void put_ascii(input logic [7:0] c);
    if (c == ChLf || c == ChTab) begin
      put_b(mode_sl ? ChSp : c);
    end else if (c < ChSp || c == ChDel) begin
      put_ctrl(c);
    end else begin
      put_b(c);
    end
  endfunction

  function automatic void flush_cr();
    if (cr_held) begin
      cr_held = 1'b0;
      if (mode_sl) begin
        put_b(ChSp);
      end else begin
        put_b(ChBsl);
        put_b(ChLowR);
      end
    end
  endfunction

  function automatic bit gather_cont(input logic [7:0] b);
    int idx;
    int need;
    logic [7:0] lead;
    idx = u8_cnt;
    lead = u8_buf[0];
    need = (lead >= Utf4Lo) ? 4 : (lead >= Utf3Lo) ? 3 : 2;
    if (b[7:6] != 2'b10) begin
      return 1'b0;
    end
    if (idx == 1) begin
      if (lead == Utf3Lo && !b[5]) begin
        return 1'b0;
      end
      if (lead == Utf4Lo && b[5:4] == 2'b00) begin
        return 1'b0;
      end
    end
    if (idx + 1 >= need) begin
      u8_cnt = 0;
      if (need == 2 && lead == Utf2Lo && b <= 8'h9f) begin
        put_ctrl(b);
      end else begin
        for (int k = 0; k < idx && k < 3; k++) begin
          put_b(u8_buf[k]);
        end
        put_b(b);
      end
    end else begin
      u8_buf[idx] = b;
      u8_cnt = idx + 1;
    end
    return 1'b1;
  endfunction

  function automatic void text_byte(input logic [7:0] c);
    if (cr_held) begin
      if (c == ChLf) begin
        cr_held = 1'b0;
        put_b(mode_sl ? ChSp : ChLf);
        return;
      end
      flush_cr();
    end
    if (c == ChCr) begin
      cr_held = 1'b1;
      return;
    end
    if (c < 8'h80) begin
      put_ascii(c);
      return;
    end
    if (c < Utf2Lo || c >= UtfBad) begin
      return;
    end
    u8_buf[0] = c;
    u8_cnt = 1;
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    case (scan_st)
      PS_TEXT: begin
        if (c inside {ChEsc, ChCsi, ChOsc, ChDcs, ChSos, ChPm, ChApc}) begin
          flush_cr();
          if (c == ChEsc) begin
            scan_st = PS_ESC;
          end else if (c == ChCsi) begin
            scan_st = PS_CSI;
          end else if (c == ChOsc) begin
            scan_st = PS_OSC;
          end else begin
            scan_st = PS_STR;
          end
        end else begin
          text_byte(c);
        end
      end
      PS_ESC: begin
        if (c == ChLbr) begin
          scan_st = PS_CSI;
        end else if (c == ChRbr) begin
          scan_st = PS_OSC;
        end else if (c inside {ChP, ChX, ChCaret, ChUnder}) begin
          scan_st = PS_STR;
        end else if (c != ChEsc) begin
          scan_st = PS_TEXT;
        end
      end
      PS_CSI: begin
        if (c >= ChFinLo && c <= ChFinHi) begin
          scan_st = PS_TEXT;
        end else if (c == ChEsc) begin
          scan_st = PS_ESC;
        end
      end
      PS_OSC: begin
        if (c == ChBel || c == ChSt) begin
          scan_st = PS_TEXT;
        end else if (c == ChEsc) begin
          scan_st = PS_OSC_ESC;
        end
      end
      PS_OSC_ESC: begin
        if (c == ChBsl) begin
          scan_st = PS_TEXT;
        end else if (c != ChEsc) begin
          scan_st = PS_OSC;
        end
      end
      PS_STR: begin
        if (c == ChSt) begin
          scan_st = PS_TEXT;
        end else if (c == ChEsc) begin
          scan_st = PS_STR_ESC;
        end
      end
      default: begin
        if (c == ChBsl) begin
          scan_st = PS_TEXT;
        end else if (c != ChEsc) begin
          scan_st = PS_STR;
        end
      end
    endcase
  endfunction

  function automatic void sanitize_item(input tty_item_t it);
    bit taken;
    text_beat_t tb;
    burst_q.delete();
    if (it.v) begin
      taken = 1'b0;
      if (u8_cnt != 0) begin
        taken = gather_cont(it.b);
      end
      if (!taken) begin
        u8_cnt = 0;
        scan_byte(it.b);
      end
    end
    if (it.fin) begin
      flush_cr();
      scan_st = PS_TEXT;
      cr_held = 1'b0;
      u8_cnt = 0;
    end
    foreach (burst_q[i]) begin
      tb.b = burst_q[i];
      tb.last = (i == burst_q.size() - 1);
      want_text_q.push_back(tb);
    end
  endfunction

  function automatic int draw_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // driver: offer pending input beats
  tty_item_t cur_item;
  int        tx_wait = 0;

  always @(posedge clk) begin
    logic nxt_push;
    if (rst) begin
      push <= 1'b0;
    end else begin
      nxt_push = push;
      if (push && !full) begin
        sanitize_item(cur_item);
        nxt_push = 1'b0;
        tx_wait = draw_gap(tx_quiet);
      end
      if (!nxt_push) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pend_q.size() != 0) begin
          cur_item = pend_q.pop_front();
          nxt_push = 1'b1;
          in_byte <= cur_item.b;
          byte_valid <= cur_item.v;
          finish <= cur_item.fin;
        end
      end
      push <= nxt_push;
    end
  end

  // monitor: pop result beats and compare
  int rx_wait = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    logic nxt_pop;
    text_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      nxt_pop = pop;
      if (pop && !empty) begin
        if (want_text_q.size() == 0) begin
          note_fail($sformatf("unexpected beat: byte %02h last %0d", out_byte, out_last));
        end else begin
          want = want_text_q.pop_front();
          if (out_byte !== want.b || out_last !== want.last) begin
            note_fail($sformatf("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                                want.b, want.last, out_byte, out_last));
          end
        end
        nxt_pop = 1'b0;
        rx_wait = draw_gap(rx_quiet);
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        nxt_pop = 1'b0;
      end
      if (!nxt_pop) begin
        if (hold_left > 0) begin
          hold_left--;
        end else if (rx_wait > 0) begin
          rx_wait--;
        end else begin
          nxt_pop = 1'b1;
        end
      end
      pop <= nxt_pop;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cyc = 0;
    end else begin
      stall_cyc++;
    end
    if (stall_cyc >= StallLimit) begin
      $display("timeout: no beat moved for %0d cycles", StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void add_item(input logic [7:0] b, input logic v, input logic fin);
    tty_item_t it;
    it.b = b;
    it.v = v;
    it.fin = fin;
    pend_q.push_back(it);
    if (v || fin) begin
      items_queued++;
    end
  endfunction

  task automatic drain_block();
    @(negedge clk);
    while (pend_q.size() != 0 || push || want_text_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_mode(input bit sl);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= sl;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_sl = sl;
  endtask

  task automatic run_phase(input bit sl, input int n, input bit tx_q, input bit rx_q,
                           input bit squeeze);
    int start;
    int k;
    int len;
    logic [7:0] lead;
    drain_block();
    set_mode(sl);
    tx_quiet = tx_q;
    rx_quiet = rx_q;
    if (squeeze) begin
      hold_go = 1'b1;
    end
    start = items_queued;
    while (items_queued - start < n) begin
      case ($urandom_range(0, 13))
        0, 1: add_item(8'($urandom_range(8'h20, 8'h7e)), 1'b1, 1'b0);
        2: begin
          case ($urandom_range(0, 5))
            0: add_item(ChCr, 1'b1, 1'b0);
            1: add_item(ChLf, 1'b1, 1'b0);
            2: add_item(ChTab, 1'b1, 1'b0);
            3: begin
              add_item(ChCr, 1'b1, 1'b0);
              add_item(ChLf, 1'b1, 1'b0);
            end
            4: add_item(8'($urandom_range(0, 31)), 1'b1, 1'b0);
            default: add_item(ChDel, 1'b1, 1'b0);
          endcase
        end
        3: begin
          add_item(ChEsc, 1'b1, 1'b0);
          add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        4: begin
          if ($urandom_range(0, 1) == 0) begin
            add_item(ChCsi, 1'b1, 1'b0);
          end else begin
            add_item(ChEsc, 1'b1, 1'b0);
            add_item(ChLbr, 1'b1, 1'b0);
          end
          repeat ($urandom_range(0, 3))
            add_item(8'($urandom_range(8'h30, 8'h3f)), 1'b1, 1'b0);
          add_item(8'($urandom_range(ChFinLo, ChFinHi)), 1'b1, 1'b0);
        end
        5: begin
          if ($urandom_range(0, 1) == 0) begin
            add_item(ChOsc, 1'b1, 1'b0);
          end else begin
            add_item(ChEsc, 1'b1, 1'b0);
            add_item(ChRbr, 1'b1, 1'b0);
          end
          repeat ($urandom_range(0, 4))
            add_item(8'($urandom_range(8'h20, 8'h7e)), 1'b1, 1'b0);
          k = $urandom_range(0, 3);
          if (k == 0) begin
            add_item(ChBel, 1'b1, 1'b0);
          end else if (k == 1) begin
            add_item(ChSt, 1'b1, 1'b0);
          end else begin
            add_item(ChEsc, 1'b1, 1'b0);
            if (k == 3) begin
              add_item(ChEsc, 1'b1, 1'b0);
            end
            add_item(ChBsl, 1'b1, 1'b0);
          end
        end
        6: begin
          k = $urandom_range(0, 3);
          if ($urandom_range(0, 1) == 0) begin
            add_item(k == 0 ? ChDcs : k == 1 ? ChSos : k == 2 ? ChPm : ChApc, 1'b1, 1'b0);
          end else begin
            add_item(ChEsc, 1'b1, 1'b0);
            add_item(k == 0 ? ChP : k == 1 ? ChX : k == 2 ? ChCaret : ChUnder, 1'b1, 1'b0);
          end
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 5) == 0) begin
              add_item(ChEsc, 1'b1, 1'b0);
            end
            add_item(8'($urandom_range(8'h20, 8'h7e)), 1'b1, 1'b0);
          end
          if ($urandom_range(0, 1) == 0) begin
            add_item(ChSt, 1'b1, 1'b0);
          end else begin
            add_item(ChEsc, 1'b1, 1'b0);
            add_item(ChBsl, 1'b1, 1'b0);
          end
        end
        7, 8: begin
          len = $urandom_range(2, 4);
          if (len == 2) begin
            lead = 8'($urandom_range(8'hc2, 8'hdf));
          end else if (len == 3) begin
            lead = 8'($urandom_range(8'he0, 8'hef));
          end else begin
            lead = 8'($urandom_range(8'hf0, 8'hf7));
          end
          add_item(lead, 1'b1, 1'b0);
          if (lead == Utf3Lo) begin
            add_item(8'($urandom_range(8'ha0, 8'hbf)), 1'b1, 1'b0);
          end else if (lead == Utf4Lo) begin
            add_item(8'($urandom_range(8'h90, 8'hbf)), 1'b1, 1'b0);
          end else begin
            add_item(8'($urandom_range(8'h80, 8'hbf)), 1'b1, 1'b0);
          end
          repeat (len - 2) add_item(8'($urandom_range(8'h80, 8'hbf)), 1'b1, 1'b0);
        end
        9: begin
          lead = 8'($urandom_range(8'hc2, 8'hf7));
          add_item(lead, 1'b1, 1'b0);
          if (lead >= Utf3Lo) begin
            repeat ($urandom_range(0, (lead >= Utf4Lo) ? 2 : 1))
              add_item(8'($urandom_range(8'h80, 8'hbf)), 1'b1, 1'b0);
          end
          add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        10: begin
          k = $urandom_range(0, 2);
          if (k == 0) begin
            add_item(8'($urandom_range(8'h80, 8'hbf)), 1'b1, 1'b0);
          end else if (k == 1) begin
            add_item(8'($urandom_range(8'hc0, 8'hc1)), 1'b1, 1'b0);
          end else begin
            add_item(8'($urandom_range(UtfBad, 8'hff)), 1'b1, 1'b0);
          end
        end
        11: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        12: begin
          add_item(Utf2Lo, 1'b1, 1'b0);
          add_item(8'($urandom_range(8'h80, 8'h9f)), 1'b1, 1'b0);
        end
        default: begin
          add_item(ChCr, 1'b1, 1'b0);
          add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
      endcase
      if ($urandom_range(0, 24) == 0) begin
        add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
      if ($urandom_range(0, 24) == 0) begin
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    u8_buf[0] = 8'h00;
    u8_buf[1] = 8'h00;
    u8_buf[2] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_mode(1'b0);

    add_item(8'h41, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(ChDel, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(ChBel, 1'b1, 1'b0);
    add_item(ChBs, 1'b1, 1'b0);
    add_item(ChTab, 1'b1, 1'b0);
    add_item(ChCr, 1'b1, 1'b0);
    add_item(ChLf, 1'b1, 1'b0);
    // C1 introducer flushes the held CR
    add_item(ChCr, 1'b1, 1'b0);
    add_item(ChCsi, 1'b1, 1'b0);
    add_item(8'h31, 1'b1, 1'b0);
    add_item(8'h6d, 1'b1, 1'b0);
    add_item(Utf2Lo, 1'b1, 1'b0);
    add_item(8'h85, 1'b1, 1'b0);
    // overlong after E0, then the offender is a bad lead
    add_item(Utf3Lo, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'hf4, 1'b1, 1'b0);
    add_item(8'h90, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'hc3, 1'b1, 1'b0);
    add_item(ChCr, 1'b1, 1'b1);
    add_item(8'he2, 1'b1, 1'b0);
    add_item(8'h5a, 1'b0, 1'b0);
    add_item(8'ha5, 1'b0, 1'b1);

    run_phase(1'b1, 90, 1'b0, 1'b0, 1'b0);
    run_phase(1'b0, 90, 1'b1, 1'b1, 1'b0);
    run_phase(1'b1, 90, 1'b1, 1'b0, 1'b1);
    run_phase(1'b0, 90, 1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 90, 1'b0, 1'b1, 1'b0);
    drain_block();

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tts_pkg.sv
sv/tts_front.sv
sv/tts_queue.sv
sv/tts_back.sv
sv/terminal_text_sanitizer_unit.sv
tb/tb_top.sv
